// ----- hdl/differential_drive_step_mixer_macros.svh -----
// Assertion macros used by the checker file of the step mixer.
`ifndef DIFFERENTIAL_DRIVE_STEP_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_STEP_MIXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step mixer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step mixer assertion failed");

`endif

// ----- hdl/ddsm_pkg.sv -----
// Types, codes and constants of the differential drive step mixer.
package ddsm_pkg;

  localparam int unsigned LevelW  = 5;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned MotionW = 3;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 5;
  localparam int unsigned MulW    = 16;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned FullW   = 9;

  // floor(x / 10) == (x * RecipTenth) >> RecipShift for every x below 81920.
  localparam logic [MulW-1:0] RecipTenth = 16'd52429;
  localparam int unsigned     RecipShift = 19;
  localparam int unsigned     QuotW      = ProdW - RecipShift;
  localparam logic [4:0]      Tenths     = 5'd10;
  localparam logic [SpeedW-1:0] SpeedMaxOut = 10'd1023;

  typedef enum logic [OpW-1:0] {
    OP_STOP  = 2'd0,
    OP_YAW   = 2'd1,
    OP_SPEED = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [MotionW-1:0] {
    MOT_STOP      = 3'd0,
    MOT_FORWARD   = 3'd1,
    MOT_BACK      = 3'd2,
    MOT_ROT_RIGHT = 3'd3,
    MOT_ROT_LEFT  = 3'd4
  } motion_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPEED_UNIT      = 3'd0,
    REG_MAX_SPEED_LEVEL = 3'd1,
    REG_MIN_SPEED_LEVEL = 3'd2,
    REG_MAX_YAW_LEVEL   = 3'd3,
    REG_ROTATE_GAIN     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [4:0] speed_unit;
    logic [3:0] max_speed_level;
    logic [3:0] min_speed_level;
    logic [3:0] max_yaw_level;
    logic [2:0] rotate_gain;
  } cfg_t;

  typedef struct packed {
    logic speed_axis;
    logic down;
  } step_req_t;

endpackage

// ----- hdl/ddsm_if.sv -----
// Handshake channel interfaces of the step mixer: command, result and register write.
interface ddsm_cmd_if import ddsm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic              direction;
  logic [CountW-1:0] step_count;

  modport source (output valid, output op, output direction, output step_count,
                  input ready);
  modport sink (input valid, input op, input direction, input step_count,
                output ready);
endinterface

interface ddsm_res_if import ddsm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MotionW-1:0]       motion;
  logic [SpeedW-1:0]        left_speed;
  logic [SpeedW-1:0]        right_speed;
  logic signed [LevelW-1:0] yaw_now;
  logic signed [LevelW-1:0] speed_now;

  modport source (output valid, output motion, output left_speed, output right_speed,
                  output yaw_now, output speed_now, input ready);
  modport sink (input valid, input motion, input left_speed, input right_speed,
                input yaw_now, input speed_now, output ready);
endinterface

interface ddsm_cfg_if import ddsm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ddsm_level_step.sv -----
// One yaw or speed level step, applied once per cycle by the sequencer.
module ddsm_level_step import ddsm_pkg::*; (
  input  cfg_t                     cfg_i,
  input  step_req_t                req_i,
  input  logic signed [LevelW-1:0] yaw_i,
  input  logic signed [LevelW-1:0] speed_i,
  output logic signed [LevelW-1:0] yaw_o,
  output logic signed [LevelW-1:0] speed_o
);

  logic signed [LevelW-1:0] yaw_lim;
  logic signed [LevelW-1:0] lo;
  logic signed [LevelW-1:0] hi;

  assign yaw_lim = $signed({1'b0, cfg_i.max_yaw_level});
  assign lo      = $signed({1'b0, cfg_i.min_speed_level});
  assign hi      = $signed({1'b0, cfg_i.max_speed_level});

  always_comb begin
    yaw_o   = yaw_i;
    speed_o = speed_i;
    if (!req_i.speed_axis) begin
      // Yaw saturates at the limit; a level already beyond it stays put outward.
      if (!req_i.down) begin
        if (yaw_i < yaw_lim) yaw_o = yaw_i + 5'sd1;
      end else begin
        if (yaw_i > -yaw_lim) yaw_o = yaw_i - 5'sd1;
      end
    end else begin
      // Speed jumps the dead zone between zero and the minimum level.
      if (!req_i.down) begin
        if (speed_i == -lo)     speed_o = '0;
        else if (speed_i == '0) speed_o = lo;
        else if (speed_i < hi)  speed_o = speed_i + 5'sd1;
      end else begin
        if (speed_i == lo)      speed_o = '0;
        else if (speed_i == '0) speed_o = -lo;
        else if (speed_i > -hi) speed_o = speed_i - 5'sd1;
      end
    end
  end

endmodule

// ----- hdl/differential_drive_step_mixer.sv -----
// Top level of the differential drive step mixer.
// The command channel cmd_i carries one drive item: op (stop, yaw steps or
// speed steps), direction and step_count. Each accepted item yields exactly
// one item on the result channel res_o with the motion code, both wheel pair
// speeds and the yaw and speed levels as they stand after the command.
// Registers are written through cfg_i, whose ready is always high; writes to
// an index past the last register are ignored.
// The block works on one item at a time. A yaw or speed item applies one
// level step per cycle, up to the clamped step count of zero to fifteen
// steps, and then leaves the step loop; stop and the unused op skip the
// loop. Then come three passes through a single shared 16x16 multiplier
// while driving, four while rotating, the last of which divides by ten
// through a reciprocal, and the format state ST_DONE builds the result.
// cmd_i.ready is high only while the sequencer is idle, so a new item is
// accepted only once the last one has left the format state.
// The result sits in an output register, so a new command is accepted while
// an earlier result still waits. If the receiver stalls, the next result
// waits in the format state until the register frees up.
// Reset clears both levels, loads the default register values and empties the output register.
module differential_drive_step_mixer import ddsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddsm_cmd_if.sink    cmd_i,
  ddsm_res_if.source  res_o,
  ddsm_cfg_if.sink    cfg_i
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  cfg_t cfg_q;

  logic signed [LevelW-1:0] yaw_q, yaw_d;
  logic signed [LevelW-1:0] speed_q, speed_d;
  logic signed [LevelW-1:0] yaw_after;
  logic signed [LevelW-1:0] speed_after;

  step_req_t         req_q, req_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [1:0]        mstep_q, mstep_d;

  logic [ProdW-1:0] acc_q, acc_d;
  logic [FullW-1:0] full_q, full_d;

  logic                     res_valid_q, res_valid_d;
  logic [MotionW-1:0]       motion_q, motion_d;
  logic [SpeedW-1:0]        left_q, left_d;
  logic [SpeedW-1:0]        right_q, right_d;
  logic signed [LevelW-1:0] yaw_out_q, yaw_out_d;
  logic signed [LevelW-1:0] speed_out_q, speed_out_d;

  logic cmd_fire;
  logic res_free;

  // Level magnitudes and the inner side factor |10 - |yaw||.
  logic [LevelW-1:0] yaw_mag;
  logic [LevelW-1:0] speed_mag;
  logic [LevelW-1:0] inner_factor;
  logic              rotating;
  logic              mul_last;

  logic [MulW-1:0]  mul_a;
  logic [MulW-1:0]  mul_b;
  logic [ProdW-1:0] mul_p;
  logic [QuotW-1:0] quot;

  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign res_free = !res_valid_q || res_o.ready;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign yaw_mag      = yaw_q[LevelW-1] ? LevelW'(-yaw_q) : LevelW'(yaw_q);
  assign speed_mag    = speed_q[LevelW-1] ? LevelW'(-speed_q) : LevelW'(speed_q);
  assign inner_factor = (yaw_mag <= Tenths) ? (Tenths - yaw_mag) : (yaw_mag - Tenths);
  assign rotating     = (speed_q == '0);
  assign mul_last     = rotating ? (mstep_q == 2'd3) : (mstep_q == 2'd2);
  assign quot         = acc_q[ProdW-1:RecipShift];

  ddsm_level_step u_step (
    .cfg_i   (cfg_q),
    .req_i   (req_q),
    .yaw_i   (yaw_q),
    .speed_i (speed_q),
    .yaw_o   (yaw_after),
    .speed_o (speed_after)
  );

  // Operand selection for the shared multiplier. Rotation runs
  // gain*|yaw|, then *max_speed_level, *speed_unit and the divide by ten.
  // Driving runs |speed|*speed_unit, then *inner factor and the divide.
  always_comb begin
    mul_a = acc_q[MulW-1:0];
    mul_b = RecipTenth;
    case (mstep_q)
      2'd0: begin
        if (rotating) begin
          mul_a = MulW'(cfg_q.rotate_gain);
          mul_b = MulW'(yaw_mag);
        end else begin
          mul_a = MulW'(speed_mag);
          mul_b = MulW'(cfg_q.speed_unit);
        end
      end
      2'd1: begin
        mul_b = rotating ? MulW'(cfg_q.max_speed_level) : MulW'(inner_factor);
      end
      2'd2: begin
        mul_b = rotating ? MulW'(cfg_q.speed_unit) : RecipTenth;
      end
      default: begin
        mul_b = RecipTenth;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    yaw_d       = yaw_q;
    speed_d     = speed_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    mstep_d     = mstep_q;
    acc_d       = acc_q;
    full_d      = full_q;
    res_valid_d = res_valid_q;
    motion_d    = motion_q;
    left_d      = left_q;
    right_d     = right_q;
    yaw_out_d   = yaw_out_q;
    speed_out_d = speed_out_q;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          mstep_d = 2'd0;
          req_d.speed_axis = (cmd_i.op == OP_SPEED);
          req_d.down       = cmd_i.direction;
          unique case (cmd_i.op)
            OP_STOP: begin
              yaw_d   = '0;
              speed_d = '0;
              state_d = ST_MUL;
            end
            OP_YAW: begin
              cnt_d   = (cmd_i.step_count > cfg_q.max_yaw_level) ?
                        cfg_q.max_yaw_level : cmd_i.step_count;
              state_d = ST_STEP;
            end
            OP_SPEED: begin
              cnt_d   = (cmd_i.step_count > cfg_q.max_speed_level) ?
                        cfg_q.max_speed_level : cmd_i.step_count;
              state_d = ST_STEP;
            end
            default: begin
              state_d = ST_MUL;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (cnt_q != '0) begin
          yaw_d   = yaw_after;
          speed_d = speed_after;
          cnt_d   = cnt_q - 1'b1;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d   = mul_p;
        mstep_d = mstep_q + 1'b1;
        if (mstep_q == 2'd0 && !rotating) begin
          full_d = mul_p[FullW-1:0];
        end
        if (mul_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          yaw_out_d   = yaw_q;
          speed_out_d = speed_q;
          if (rotating) begin
            if (yaw_q > 0)      motion_d = MOT_ROT_RIGHT;
            else if (yaw_q < 0) motion_d = MOT_ROT_LEFT;
            else                motion_d = MOT_STOP;
            left_d  = (quot > QuotW'(SpeedMaxOut)) ? SpeedMaxOut : quot[SpeedW-1:0];
            right_d = (quot > QuotW'(SpeedMaxOut)) ? SpeedMaxOut : quot[SpeedW-1:0];
          end else begin
            // The inner side slows down; the outer side keeps full speed.
            motion_d = (speed_q > 0) ? MOT_FORWARD : MOT_BACK;
            left_d   = (yaw_q < 0) ? quot[SpeedW-1:0] : SpeedW'(full_q);
            right_d  = (yaw_q > 0) ? quot[SpeedW-1:0] : SpeedW'(full_q);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      yaw_q       <= '0;
      speed_q     <= '0;
      cnt_q       <= '0;
      mstep_q     <= '0;
      req_q       <= '0;
      res_valid_q <= 1'b0;
      cfg_q.speed_unit      <= 5'd10;
      cfg_q.max_speed_level <= 4'd10;
      cfg_q.min_speed_level <= 4'd3;
      cfg_q.max_yaw_level   <= 4'd5;
      cfg_q.rotate_gain     <= 3'd2;
    end else begin
      state_q     <= state_d;
      yaw_q       <= yaw_d;
      speed_q     <= speed_d;
      cnt_q       <= cnt_d;
      mstep_q     <= mstep_d;
      req_q       <= req_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_SPEED_UNIT:      cfg_q.speed_unit      <= cfg_i.data;
          REG_MAX_SPEED_LEVEL: cfg_q.max_speed_level <= cfg_i.data[3:0];
          REG_MIN_SPEED_LEVEL: cfg_q.min_speed_level <= cfg_i.data[3:0];
          REG_MAX_YAW_LEVEL:   cfg_q.max_yaw_level   <= cfg_i.data[3:0];
          REG_ROTATE_GAIN:     cfg_q.rotate_gain     <= cfg_i.data[2:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath and result payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    full_q      <= full_d;
    motion_q    <= motion_d;
    left_q      <= left_d;
    right_q     <= right_d;
    yaw_out_q   <= yaw_out_d;
    speed_out_q <= speed_out_d;
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.motion      = motion_q;
  assign res_o.left_speed  = left_q;
  assign res_o.right_speed = right_q;
  assign res_o.yaw_now     = yaw_out_q;
  assign res_o.speed_now   = speed_out_q;

endmodule

// ----- hdl/ddsm_checker.sv -----
// Port-level checker of the step mixer and its bind to the top level.
`include "differential_drive_step_mixer_macros.svh"

module ddsm_checker import ddsm_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cmd_valid_i,
  input logic                     cmd_ready_i,
  input logic                     res_valid_i,
  input logic                     res_ready_i,
  input logic [MotionW-1:0]       motion_i,
  input logic [SpeedW-1:0]        left_speed_i,
  input logic [SpeedW-1:0]        right_speed_i,
  input logic signed [LevelW-1:0] yaw_now_i,
  input logic signed [LevelW-1:0] speed_now_i
);

  // A pending result is not withdrawn before it is taken.
  `DDSM_ASSERT_NEXT(a_res_holds, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)

  // The sequencer is busy in the cycle after it takes a command.
  `DDSM_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni, cmd_valid_i && cmd_ready_i, !cmd_ready_i)

  // A stop result means both levels are zero and both pairs stand still.
  `DDSM_ASSERT_IMPL(a_stop_still, clk_i, rst_ni, res_valid_i && motion_i == MOT_STOP, yaw_now_i == '0 && speed_now_i == '0 && left_speed_i == '0 && right_speed_i == '0)

  // Rotation in place only at speed level zero, with equal pair speeds.
  `DDSM_ASSERT_IMPL(a_rotate_equal, clk_i, rst_ni, res_valid_i && (motion_i == MOT_ROT_RIGHT || motion_i == MOT_ROT_LEFT), speed_now_i == '0 && left_speed_i == right_speed_i)

endmodule

bind differential_drive_step_mixer ddsm_checker u_ddsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .motion_i      (res_o.motion),
  .left_speed_i  (res_o.left_speed),
  .right_speed_i (res_o.right_speed),
  .yaw_now_i     (res_o.yaw_now),
  .speed_now_i   (res_o.speed_now)
);
